// ===== hdl/pirl_pkg.sv =====
// ----------------------------------------------------------------------------
// pirl_pkg
// Shared types and codes for the positional insert/remove list.
// ----------------------------------------------------------------------------
package pirl_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] element_count;
        logic [STAT_W-1:0]  status;
    } rsp_t;

    typedef enum logic {
        CTRL_EMPTY,
        CTRL_HOLD
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic list_empty;
        logic list_full;
    } dp_stat_t;

endpackage

// ===== hdl/positional_insert_remove_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_remove_list
// Fixed-capacity ordered list with insert, remove and read at a position.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, payload req): one command per transfer,
//   insert at 1-based position 1..count+1, remove or read at 1..count.
//   rsp channel (rsp_valid/rsp_ready, payload rsp): exactly one result per
//   command, carrying the read value (zero unless a read succeeded), the
//   element count after the command and a status (done, out of range, full).
//   The result is registered and valid the cycle after the command transfer.
//   Throughput: one command per cycle while results are taken; every entry cell shifts in parallel
//   in the accept cycle, so the row of cells sets the per-command cost.
//   A new command is taken while a result waits only if rsp_ready is high
//   in that cycle: the single result register drains and refills at once.
//   When the receiver stalls, the result holds and req_ready drops.
//   Reset empties the list (count zero); entry contents are not cleared and
//   are only visible after an insert has written them.
// ----------------------------------------------------------------------------
module positional_insert_remove_list
#(
    parameter int CAPACITY      = pirl_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = pirl_pkg::ELEMENT_WIDTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pirl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pirl_pkg::rsp_t rsp
);

    // command from controller, status back from datapath
    pirl_pkg::dp_cmd_t  cmd;
    pirl_pkg::dp_stat_t stat;

    // sequence the handshake and the result slot
    pirl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // hold entries and count, compute each result
    pirl_datapath
    #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    )
    u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== hdl/pirl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pirl_ctrl
// Handshake controller: one output register slot, refilled on the same
// cycle it drains.
// ----------------------------------------------------------------------------
module pirl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pirl_pkg::dp_cmd_t  cmd,
    input  pirl_pkg::dp_stat_t stat
);

    pirl_pkg::ctrl_state_t state_reg;
    pirl_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pirl_pkg::CTRL_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            pirl_pkg::CTRL_EMPTY:
            begin
                req_ready = 1'b1;
                cmd.exec  = req_valid;
                if (req_valid)
                begin
                    state_next = pirl_pkg::CTRL_HOLD;
                end
            end
            pirl_pkg::CTRL_HOLD:
            begin
                rsp_valid = 1'b1;
                req_ready = rsp_ready;
                cmd.exec  = req_valid && rsp_ready;
                if (rsp_ready && !req_valid)
                begin
                    state_next = pirl_pkg::CTRL_EMPTY;
                end
            end
            default:
            begin
                state_next = pirl_pkg::CTRL_EMPTY;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an executed command always leaves a result waiting
    a_exec_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> state_reg == pirl_pkg::CTRL_HOLD)
        else $error("result slot not filled after execute");

    // count bounds seen from the datapath never claim both empty and full
    a_stat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.list_empty && stat.list_full))
        else $error("list reported empty and full at once");

    // a held result that is not taken stays held
    a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pirl_pkg::CTRL_HOLD && !rsp_ready) |=>
            state_reg == pirl_pkg::CTRL_HOLD)
        else $error("result dropped while stalled");
`endif

endmodule

// ===== hdl/pirl_datapath.sv =====
// ----------------------------------------------------------------------------
// pirl_datapath
// Row of entry cells that shift up or down in parallel, the count register
// and the result register.
// ----------------------------------------------------------------------------
module pirl_datapath
#(
    parameter int CAPACITY      = pirl_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = pirl_pkg::ELEMENT_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pirl_pkg::dp_cmd_t  cmd,
    output pirl_pkg::dp_stat_t stat,
    input  pirl_pkg::req_t     req,
    output pirl_pkg::rsp_t     rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = CNT_W + pirl_pkg::POS_W + 1;

    logic [ELEMENT_WIDTH-1:0] entries_reg [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] below       [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] above       [CAPACITY];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    pirl_pkg::rsp_t    rsp_reg;
    pirl_pkg::rsp_t    rsp_next;

    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         idx_ext;
    logic [IDX_W-1:0]         rd_idx;
    logic [ELEMENT_WIDTH-1:0] new_elem;
    logic                     pos_nonzero;
    logic                     do_insert;
    logic                     do_remove;

    assign pos_ext     = CMP_W'(req.position);
    assign cnt_ext     = CMP_W'(count_reg);
    assign idx_ext     = pos_ext - CMP_W'(1);
    assign rd_idx      = idx_ext[IDX_W-1:0];
    assign new_elem    = ELEMENT_WIDTH'(req.value);
    assign pos_nonzero = (req.position != '0);

    always_comb
    begin
        count_next             = count_reg;
        do_insert              = 1'b0;
        do_remove              = 1'b0;
        rsp_next.read_value    = '0;
        rsp_next.status        = pirl_pkg::STAT_RANGE;
        priority if (req.command == pirl_pkg::CMD_INSERT)
        begin
            if (pos_nonzero && pos_ext <= cnt_ext + CMP_W'(1))
            begin
                if (cnt_ext >= CMP_W'(CAPACITY))
                begin
                    rsp_next.status = pirl_pkg::STAT_FULL;
                end
                else
                begin
                    do_insert       = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    rsp_next.status = pirl_pkg::STAT_DONE;
                end
            end
        end
        else if (req.command == pirl_pkg::CMD_REMOVE)
        begin
            if (pos_nonzero && pos_ext <= cnt_ext)
            begin
                do_remove       = 1'b1;
                count_next      = count_reg - CNT_W'(1);
                rsp_next.status = pirl_pkg::STAT_DONE;
            end
        end
        else if (req.command == pirl_pkg::CMD_READ)
        begin
            if (pos_nonzero && pos_ext <= cnt_ext)
            begin
                rsp_next.read_value = pirl_pkg::VALUE_W'(entries_reg[rd_idx]);
                rsp_next.status     = pirl_pkg::STAT_DONE;
            end
        end
        else
        begin
            // unused command code: report out of range, change nothing
            rsp_next.status = pirl_pkg::STAT_RANGE;
        end
        rsp_next.element_count = pirl_pkg::COUNT_W'(count_next);
    end

    // neighbor taps for the shift chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_tap
        if (i == 0)
        begin : g_lo
            assign below[i] = '0;
        end
        else
        begin : g_lo
            assign below[i] = entries_reg[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_hi
            assign above[i] = '0;
        end
        else
        begin : g_hi
            assign above[i] = entries_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec && do_insert)
            begin
                if (CMP_W'(i) == idx_ext)
                begin
                    entries_reg[i] <= new_elem;
                end
                else if (CMP_W'(i) > idx_ext)
                begin
                    entries_reg[i] <= below[i];
                end
            end
            else if (cmd.exec && do_remove)
            begin
                if (CMP_W'(i) >= idx_ext)
                begin
                    entries_reg[i] <= above[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp             = rsp_reg;
    assign stat.list_empty = (count_reg == '0);
    assign stat.list_full  = (count_reg == CNT_W'(CAPACITY));

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("count moved without a command");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && do_insert) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && do_remove) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not shrink the list");
`endif

endmodule

// ===== tb/tb_positional_insert_remove_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_insert_remove_list
// Self-checking bench for the positional insert/remove list. A tracker keeps
// its own copy of the list and predicts each result. Directed commands hit the
// edge cases first. Random command streams then walk the count up to full and
// back down to empty, with bursty traffic on the request side and a changing
// stall pattern on the response side.
// ----------------------------------------------------------------------------
module tb_positional_insert_remove_list;

    localparam int LIST_CAPACITY = pirl_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS  = 925;
    // Command code the block does not define; it must come back as out of range.
    localparam logic [pirl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Tracker: shadow copy of the list plus the queue of results still owed
    // ------------------------------------------------------------------------
    class list_tracker;
        logic [pirl_pkg::VALUE_W-1:0] entries [LIST_CAPACITY];
        int                           count;
        pirl_pkg::rsp_t               owed_results [$];
        int                           mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted command to the shadow list and queue its result.
        function void note_command(pirl_pkg::req_t c);
            pirl_pkg::rsp_t r;
            int             p;
            int             i;
            r.read_value = '0;
            r.status     = pirl_pkg::STAT_RANGE;
            p            = c.position;
            case (c.command)
                pirl_pkg::CMD_INSERT:
                begin
                    // Position is checked before fullness.
                    if (p >= 1 && p <= count + 1)
                    begin
                        if (count >= LIST_CAPACITY)
                            r.status = pirl_pkg::STAT_FULL;
                        else
                        begin
                            for (i = count; i >= p; i--)
                                entries[i] = entries[i-1];
                            entries[p-1] = c.value;
                            count++;
                            r.status = pirl_pkg::STAT_DONE;
                        end
                    end
                end
                pirl_pkg::CMD_REMOVE:
                begin
                    if (p >= 1 && p <= count)
                    begin
                        for (i = p - 1; i + 1 < count; i++)
                            entries[i] = entries[i+1];
                        count--;
                        r.status = pirl_pkg::STAT_DONE;
                    end
                end
                pirl_pkg::CMD_READ:
                begin
                    if (p >= 1 && p <= count)
                    begin
                        r.read_value = entries[p-1];
                        r.status     = pirl_pkg::STAT_DONE;
                    end
                end
                default:
                    r.status = pirl_pkg::STAT_RANGE;
            endcase
            r.element_count = pirl_pkg::COUNT_W'(count);
            owed_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(pirl_pkg::rsp_t got);
            pirl_pkg::rsp_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result with nothing owed: read_value %h count %0d status %0d",
                         $time, got.read_value, got.element_count, got.status);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, got.read_value);
                mismatches++;
            end
            if (got.element_count !== want.element_count)
            begin
                $display("%0t: element_count expected %0d actual %0d",
                         $time, want.element_count, got.element_count);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    pirl_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    pirl_pkg::rsp_t rsp;

    list_tracker tracker;

    // Drift direction of the random stream: grow toward full or shrink to empty.
    bit growing = 1'b1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    positional_insert_remove_list u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Present one command and hold it until the transfer happens. Valid stays
    // high on return so back-to-back commands follow without a gap.
    task automatic send_command(input pirl_pkg::req_t c);
        req_valid <= 1'b1;
        req       <= c;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.note_command(c);
    endtask

    task automatic send_fields(input logic [pirl_pkg::CMD_W-1:0] cmd, input int pos,
                               input logic [pirl_pkg::VALUE_W-1:0] val);
        pirl_pkg::req_t c;
        c.command  = cmd;
        c.position = pirl_pkg::POS_W'(pos);
        c.value    = val;
        send_command(c);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (tracker.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Build the next random command from the predicted count. Most commands
    // are in range so the list really fills and empties; a few are noise or
    // deliberately out of range for the current count.
    function automatic pirl_pkg::req_t next_random_command();
        pirl_pkg::req_t c;
        int             n;
        int             roll;
        int             pick;
        n    = tracker.count;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            c.value = '0;
        else if (pick < 16)
            c.value = '1;
        else
            c.value = $urandom();

        // Turn around at the ends, and now and then in the middle.
        if (n == 0)
            growing = 1'b1;
        else if (n == LIST_CAPACITY && $urandom_range(0, 3) == 0)
            growing = 1'b0;
        else if ($urandom_range(0, 63) == 0)
            growing = !growing;

        if (roll < 5)
        begin
            // Pure noise, unused command code included.
            c.command  = pirl_pkg::CMD_W'($urandom_range(0, 3));
            c.position = pirl_pkg::POS_W'($urandom_range(0, 31));
        end
        else if (roll < 10)
        begin
            // Broken command: position zero or past the valid end.
            case ($urandom_range(0, 2))
                0:       c.command = pirl_pkg::CMD_INSERT;
                1:       c.command = pirl_pkg::CMD_REMOVE;
                default: c.command = pirl_pkg::CMD_READ;
            endcase
            if ($urandom_range(0, 3) == 0)
                c.position = '0;
            else if (c.command == pirl_pkg::CMD_INSERT)
                c.position = pirl_pkg::POS_W'($urandom_range(n + 2, 31));
            else
                c.position = pirl_pkg::POS_W'($urandom_range(n + 1, 31));
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < (growing ? 60 : 20))
            begin
                c.command = pirl_pkg::CMD_INSERT;
                pick      = $urandom_range(0, 99);
                if (pick < 25)
                    c.position = pirl_pkg::POS_W'(n + 1);
                else if (pick < 40)
                    c.position = pirl_pkg::POS_W'(1);
                else
                    c.position = pirl_pkg::POS_W'($urandom_range(1, n + 1));
            end
            else
            begin
                c.command  = (pick < 80) ? pirl_pkg::CMD_REMOVE : pirl_pkg::CMD_READ;
                c.position = (n == 0) ? pirl_pkg::POS_W'(1)
                                      : pirl_pkg::POS_W'($urandom_range(1, n));
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Response side: check every transfer and stall on a changing pattern
    // ------------------------------------------------------------------------
    int rx_mode    = 0;
    int rx_left    = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            tracker.check_result(rsp);

        // Pick a new stall behavior when the current run of it ends.
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        else
            rx_left--;

        case (rx_mode)
            0:  rsp_ready <= 1'b1;
            1:  rsp_ready <= ($urandom_range(0, 3) != 0);
            2:  rsp_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                // Long stalls now and then, ready otherwise.
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 12);
                    rsp_ready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int  sent;
        int  burst;
        int  gap;
        int  k;
        bit  drained_mid;
        tracker     = new();
        drained_mid = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, bad positions, head/middle/append inserts.
        send_fields(pirl_pkg::CMD_READ,   1, 32'h1234_5678);
        send_fields(pirl_pkg::CMD_REMOVE, 1, 32'hFFFF_FFFF);
        send_fields(pirl_pkg::CMD_INSERT, 0, 32'hDEAD_BEEF);
        send_fields(pirl_pkg::CMD_INSERT, 2, 32'hDEAD_BEEF);
        send_fields(pirl_pkg::CMD_INSERT, 1, 32'hFFFF_FFFF);
        send_fields(pirl_pkg::CMD_INSERT, 2, 32'h0000_0000);
        send_fields(pirl_pkg::CMD_INSERT, 1, 32'hA5A5_A5A5);
        send_fields(pirl_pkg::CMD_INSERT, 2, 32'h5A5A_5A5A);
        send_fields(pirl_pkg::CMD_READ,   0, 32'h0);
        send_fields(pirl_pkg::CMD_READ,   4, 32'h0);
        send_fields(pirl_pkg::CMD_READ,   5, 32'h0);
        send_fields(CMD_UNUSED,           1, 32'hFFFF_FFFF);
        // Remove from the middle, the tail, and at position zero.
        send_fields(pirl_pkg::CMD_REMOVE, 2, 32'h0);
        send_fields(pirl_pkg::CMD_REMOVE, 3, 32'h0);
        send_fields(pirl_pkg::CMD_REMOVE, 0, 32'h0);

        // Fill to capacity, alternating appends and head inserts.
        for (k = tracker.count; k < LIST_CAPACITY; k++)
            send_fields(pirl_pkg::CMD_INSERT, (k % 2 == 0) ? k + 1 : 1,
                        32'h1000_0000 + k);

        // Full list: a valid position reports full, a bad one reports range.
        send_fields(pirl_pkg::CMD_INSERT, LIST_CAPACITY + 1, 32'hFFFF_FFFF);
        send_fields(pirl_pkg::CMD_INSERT, 1, 32'h0);
        send_fields(pirl_pkg::CMD_INSERT, LIST_CAPACITY + 2, 32'h0);
        send_fields(pirl_pkg::CMD_READ,   LIST_CAPACITY, 32'h0);
        send_fields(pirl_pkg::CMD_READ,   LIST_CAPACITY + 1, 32'h0);
        send_fields(pirl_pkg::CMD_REMOVE, LIST_CAPACITY, 32'h0);

        hold_until_drained();

        // Random bursts with random gaps; drain fully once midway.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                send_command(next_random_command());
                sent++;
            end
            if (!drained_mid && sent >= RANDOM_ITEMS / 2)
            begin
                drained_mid = 1'b1;
                hold_until_drained();
            end
            else
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        // Let the last results drain, then keep watching for strays.
        hold_until_drained();
        repeat (10) @(posedge clk);

        if (tracker.owed_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, tracker.owed_results.size());

        if (tracker.mismatches == 0 && tracker.owed_results.size() == 0)
            $display("tb_positional_insert_remove_list OK");
        else
            $display("tb_positional_insert_remove_list NOT OK");
        $finish;
    end

    // Watchdog against a hung run.
    initial
    begin
        #2_000_000;
        $display("tb_positional_insert_remove_list NOT OK");
        $finish;
    end

endmodule

// ===== positional_insert_remove_list.f =====
hdl/pirl_pkg.sv
hdl/pirl_ctrl.sv
hdl/pirl_datapath.sv
hdl/positional_insert_remove_list.sv
tb/tb_positional_insert_remove_list.sv
